// File: hdl/assert_macros.svh
// Concurrent assertion helpers, sampled on clk and off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DCMQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcmq assertion failed");

// Next-cycle implication.
`define DCMQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcmq assertion failed");

`endif

// File: hdl/dcmq_pkg.sv
`timescale 1ns / 1ps
package dcmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 18;               // field width
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int PRE_LIM   = 2 * ONE - 1;

  localparam int TR_W      = DW + 2;           // trace
  localparam int ARG_W     = DW + 4;           // 1 + 2d - T
  localparam int NDIF_W    = DW + 1;           // off-diagonal sum or difference
  localparam int C_W       = DW;               // pre-normalization component
  localparam int SQ_W      = 2 * (C_W - 1);
  localparam int SUM_W     = SQ_W + 2;

  localparam int RAD_W     = 38;               // square root radicand
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;

  localparam int QB        = 18;               // quotient bits per divide
  localparam int DEN_W     = 20;

  typedef enum logic [1:0] {
    PIV_T,
    PIV_I,
    PIV_J,
    PIV_K
  } piv_t;

endpackage

// File: hdl/dcm_to_quaternion_unit.sv
`timescale 1ns / 1ps
// Direction cosine matrix to unit quaternion (Shepperd's method), fully
// pipelined: one transaction per clock in, one per clock out, unless the
// pipe holds as described below. The pipe consists of four chains of
// one-bit cells: a 19-cell square root for the pivot, an 18-cell divider
// (three lanes) for the other components, a 19-cell square root for the
// magnitude and an 18-cell divider (four lanes) for the normalization,
// plus seven single registers around them. The whole chain moves together;
// it holds only while its last stage carries a result and the output
// register is still occupied and not being read. Bubbles do not drain during
// a hold, so in_ready drops as soon as a finished result waits behind the
// occupied output register, however empty the rest of the pipe is.
// Degenerate inputs (non-positive trace on the trace branch, negative root
// argument, zero pivot, zero magnitude) return all zeros with out_status = 1.
`include "assert_macros.svh"
module dcm_to_quaternion_unit import dcmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] in_m00,
  input  logic signed [DW-1:0] in_m01,
  input  logic signed [DW-1:0] in_m02,
  input  logic signed [DW-1:0] in_m10,
  input  logic signed [DW-1:0] in_m11,
  input  logic signed [DW-1:0] in_m12,
  input  logic signed [DW-1:0] in_m20,
  input  logic signed [DW-1:0] in_m21,
  input  logic signed [DW-1:0] in_m22,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_q_scalar,
  output logic signed [DW-1:0] out_q_i,
  output logic signed [DW-1:0] out_q_j,
  output logic signed [DW-1:0] out_q_k,
  output logic                 out_status
);

  localparam int SQ = ROOT_W;  // cells per square root
  localparam int DV = QB;      // cells per divide

  // side data riding along the arithmetic chains
  typedef struct packed {
    logic                   bad;
    piv_t                   piv;
    logic [2:0][NDIF_W-1:0] n;
  } s1_t;

  typedef struct packed {
    logic              bad;
    piv_t              piv;
    logic [ROOT_W-1:0] p;
    logic [2:0]        sgn;
    logic [2:0]        ovf;
  } s2_t;

  typedef struct packed {
    logic                bad;
    logic [3:0][C_W-1:0] c;
  } s3_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] sgn;
  } s4_t;

  logic adv;       // whole pipe moves
  logic out_ld;    // output register takes the last stage

  // ---------------------------------------------------------------- stage A
  logic signed [TR_W-1:0]   e00, e11, e22, tr, d_a;
  logic signed [NDIF_W-1:0] n_a [3];
  logic signed [ARG_W-1:0]  arg_a;
  logic                     br_t, br_i, br_j, bad_a;
  piv_t                     piv_a;

  always_comb begin
    e00  = TR_W'(in_m00);
    e11  = TR_W'(in_m11);
    e22  = TR_W'(in_m22);
    tr   = e00 + e11 + e22;
    br_t = (tr > e00) && (tr > e11) && (tr > e22);
    br_i = (e00 > e11) && (e00 > e22);
    br_j = (e11 > e22);
    priority if (br_t) begin
      piv_a  = PIV_T;
      d_a    = tr;
      n_a[0] = NDIF_W'(in_m12) - NDIF_W'(in_m21);
      n_a[1] = NDIF_W'(in_m20) - NDIF_W'(in_m02);
      n_a[2] = NDIF_W'(in_m01) - NDIF_W'(in_m10);
    end else if (br_i) begin
      piv_a  = PIV_I;
      d_a    = e00;
      n_a[0] = NDIF_W'(in_m12) - NDIF_W'(in_m21);
      n_a[1] = NDIF_W'(in_m01) + NDIF_W'(in_m10);
      n_a[2] = NDIF_W'(in_m20) + NDIF_W'(in_m02);
    end else if (br_j) begin
      piv_a  = PIV_J;
      d_a    = e11;
      n_a[0] = NDIF_W'(in_m20) - NDIF_W'(in_m02);
      n_a[1] = NDIF_W'(in_m01) + NDIF_W'(in_m10);
      n_a[2] = NDIF_W'(in_m12) + NDIF_W'(in_m21);
    end else begin
      piv_a  = PIV_K;
      d_a    = e22;
      n_a[0] = NDIF_W'(in_m01) - NDIF_W'(in_m10);
      n_a[1] = NDIF_W'(in_m20) + NDIF_W'(in_m02);
      n_a[2] = NDIF_W'(in_m12) + NDIF_W'(in_m21);
    end
    arg_a = ARG_W'(ONE) + (ARG_W'(d_a) <<< 1) - ARG_W'(tr);
    bad_a = (br_t && !(tr > 0)) || arg_a[ARG_W-1];
  end

  // stage A register and side line along the first square root
  logic [SQ:0]      v1_r;
  s1_t              s1_r [SQ+1];
  logic [RAD_W-1:0] rad1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
    end else if (adv) begin
      v1_r <= {v1_r[SQ-1:0], in_valid};
      for (int s = SQ; s > 0; s--) s1_r[s] <= s1_r[s-1];
      s1_r[0].bad <= bad_a;
      s1_r[0].piv <= piv_a;
      for (int k = 0; k < 3; k++) s1_r[0].n[k] <= n_a[k];
      rad1_r <= RAD_W'(arg_a[ARG_W-2:0]) << (FRAC_BITS - 2);
    end
  end

  // ------------------------------------------------------ pivot square root
  logic [REM_W-1:0]  sq1_rem  [SQ+1];
  logic [ROOT_W-1:0] sq1_root [SQ+1];
  logic [RAD_W-1:0]  sq1_rad  [SQ+1];

  assign sq1_rem[0]  = '0;
  assign sq1_root[0] = '0;
  assign sq1_rad[0]  = rad1_r;

  for (genvar s = 0; s < SQ; s++) begin : g_sq1
    dcmq_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (sq1_rem[s]),
      .root_i (sq1_root[s]),
      .rad_i  (sq1_rad[s]),
      .rem_o  (sq1_rem[s+1]),
      .root_o (sq1_root[s+1]),
      .rad_o  (sq1_rad[s+1])
    );
  end

  // ---------------------------------------------------------------- stage B
  localparam int NUM1_W = NDIF_W + FRAC_BITS;

  logic [ROOT_W-1:0] p_b;
  logic [DEN_W-1:0]  den_b;
  logic [NDIF_W-1:0] nabs_b [3];
  logic [NUM1_W-1:0] num_b  [3];

  always_comb begin
    p_b   = sq1_root[SQ];
    den_b = DEN_W'({p_b, 2'b00});
    for (int k = 0; k < 3; k++) begin
      nabs_b[k] = s1_r[SQ].n[k][NDIF_W-1] ? NDIF_W'(-s1_r[SQ].n[k]) : s1_r[SQ].n[k];
      num_b[k]  = {nabs_b[k], {FRAC_BITS{1'b0}}};
    end
  end

  logic [DV:0]      v2_r;
  s2_t              s2_r [DV+1];
  logic [DEN_W-1:0] d1_rem0_r [3];
  logic [QB-1:0]    d1_low0_r [3];
  logic [DEN_W-1:0] d1_den0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= '0;
    end else if (adv) begin
      v2_r <= {v2_r[DV-1:0], v1_r[SQ]};
      for (int s = DV; s > 0; s--) s2_r[s] <= s2_r[s-1];
      s2_r[0].bad <= s1_r[SQ].bad || (p_b == '0);
      s2_r[0].piv <= s1_r[SQ].piv;
      s2_r[0].p   <= p_b;
      d1_den0_r   <= den_b;
      for (int k = 0; k < 3; k++) begin
        s2_r[0].sgn[k] <= s1_r[SQ].n[k][NDIF_W-1];
        s2_r[0].ovf[k] <= DEN_W'(num_b[k][NUM1_W-1:QB]) >= den_b;
        d1_rem0_r[k]   <= DEN_W'(num_b[k][NUM1_W-1:QB]);
        d1_low0_r[k]   <= num_b[k][QB-1:0];
      end
    end
  end

  // ------------------------------------------- off-diagonal divide, 3 lanes
  logic [DEN_W-1:0] d1_rem [3][DV+1];
  logic [QB-1:0]    d1_low [3][DV+1];
  logic [QB-1:0]    d1_quo [3][DV+1];
  logic [DEN_W-1:0] d1_den [3][DV+1];

  for (genvar k = 0; k < 3; k++) begin : g_d1_lane
    assign d1_rem[k][0] = d1_rem0_r[k];
    assign d1_low[k][0] = d1_low0_r[k];
    assign d1_quo[k][0] = '0;
    assign d1_den[k][0] = d1_den0_r;
    for (genvar s = 0; s < DV; s++) begin : g_cell
      dcmq_div_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .rem_i (d1_rem[k][s]),
        .low_i (d1_low[k][s]),
        .quo_i (d1_quo[k][s]),
        .den_i (d1_den[k][s]),
        .rem_o (d1_rem[k][s+1]),
        .low_o (d1_low[k][s+1]),
        .quo_o (d1_quo[k][s+1]),
        .den_o (d1_den[k][s+1])
      );
    end
  end

  // ---------------------------------------------------------------- stage C
  logic [C_W-2:0]        pmag_c;
  logic [C_W-2:0]        xmag_c [3];
  logic signed [C_W-1:0] x_c    [3];
  logic signed [C_W-1:0] ps_c;
  logic signed [C_W-1:0] c_c    [4];

  always_comb begin
    pmag_c = (s2_r[DV].p > ROOT_W'(PRE_LIM)) ? (C_W-1)'(PRE_LIM) : (C_W-1)'(s2_r[DV].p);
    ps_c   = C_W'(pmag_c);
    for (int k = 0; k < 3; k++) begin
      xmag_c[k] = (s2_r[DV].ovf[k] || d1_quo[k][DV] > QB'(PRE_LIM)) ?
                  (C_W-1)'(PRE_LIM) : (C_W-1)'(d1_quo[k][DV]);
      x_c[k]    = s2_r[DV].sgn[k] ? -C_W'(xmag_c[k]) : C_W'(xmag_c[k]);
    end
    unique case (s2_r[DV].piv)
      PIV_T: begin
        c_c[0] = ps_c;   c_c[1] = x_c[0]; c_c[2] = x_c[1]; c_c[3] = x_c[2];
      end
      PIV_I: begin
        c_c[0] = x_c[0]; c_c[1] = ps_c;   c_c[2] = x_c[1]; c_c[3] = x_c[2];
      end
      PIV_J: begin
        c_c[0] = x_c[0]; c_c[1] = x_c[1]; c_c[2] = ps_c;   c_c[3] = x_c[2];
      end
      default: begin
        c_c[0] = x_c[0]; c_c[1] = x_c[1]; c_c[2] = x_c[2]; c_c[3] = ps_c;
      end
    endcase
  end

  logic                  v_c_r, v_d_r;
  logic                  bad_c_r, bad_d_r;
  logic signed [C_W-1:0] c_c_r [4];
  logic signed [C_W-1:0] c_d_r [4];
  logic [SQ_W-1:0]       sq_d_r [4];
  logic [C_W-2:0]        cabs_c [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cabs_c[i] = c_c_r[i][C_W-1] ? (C_W-1)'(-c_c_r[i]) : (C_W-1)'(c_c_r[i]);
    end
  end

  // stage C and stage D (squares)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (adv) begin
      v_c_r   <= v2_r[DV];
      v_d_r   <= v_c_r;
      bad_c_r <= s2_r[DV].bad;
      bad_d_r <= bad_c_r;
      for (int i = 0; i < 4; i++) begin
        c_c_r[i]  <= c_c[i];
        c_d_r[i]  <= c_c_r[i];
        sq_d_r[i] <= cabs_c[i] * cabs_c[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage E
  logic [SUM_W-1:0] ss_e;

  assign ss_e = SUM_W'(sq_d_r[0]) + SUM_W'(sq_d_r[1]) + SUM_W'(sq_d_r[2]) +
                SUM_W'(sq_d_r[3]);

  logic [SQ:0]      v3_r;
  s3_t              s3_r [SQ+1];
  logic [RAD_W-1:0] rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= '0;
    end else if (adv) begin
      v3_r <= {v3_r[SQ-1:0], v_d_r};
      for (int s = SQ; s > 0; s--) s3_r[s] <= s3_r[s-1];
      s3_r[0].bad <= bad_d_r;
      for (int i = 0; i < 4; i++) s3_r[0].c[i] <= c_d_r[i];
      rad2_r <= RAD_W'(ss_e);
    end
  end

  // -------------------------------------------------- magnitude square root
  logic [REM_W-1:0]  sq2_rem  [SQ+1];
  logic [ROOT_W-1:0] sq2_root [SQ+1];
  logic [RAD_W-1:0]  sq2_rad  [SQ+1];

  assign sq2_rem[0]  = '0;
  assign sq2_root[0] = '0;
  assign sq2_rad[0]  = rad2_r;

  for (genvar s = 0; s < SQ; s++) begin : g_sq2
    dcmq_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (sq2_rem[s]),
      .root_i (sq2_root[s]),
      .rad_i  (sq2_rad[s]),
      .rem_o  (sq2_rem[s+1]),
      .root_o (sq2_root[s+1]),
      .rad_o  (sq2_rad[s+1])
    );
  end

  // ---------------------------------------------------------------- stage F
  localparam int NUM2_W = C_W - 1 + FRAC_BITS;

  logic [C_W-2:0]    cabs_f [4];
  logic [NUM2_W-1:0] num_f  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cabs_f[i] = s3_r[SQ].c[i][C_W-1] ? (C_W-1)'(-s3_r[SQ].c[i]) : (C_W-1)'(s3_r[SQ].c[i]);
      num_f[i]  = {cabs_f[i], {FRAC_BITS{1'b0}}};
    end
  end

  logic [DV:0]      v4_r;
  s4_t              s4_r [DV+1];
  logic [DEN_W-1:0] d2_rem0_r [4];
  logic [QB-1:0]    d2_low0_r [4];
  logic [DEN_W-1:0] d2_den0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= '0;
    end else if (adv) begin
      v4_r <= {v4_r[DV-1:0], v3_r[SQ]};
      for (int s = DV; s > 0; s--) s4_r[s] <= s4_r[s-1];
      s4_r[0].bad <= s3_r[SQ].bad || (sq2_root[SQ] == '0);
      d2_den0_r   <= DEN_W'(sq2_root[SQ]);
      for (int i = 0; i < 4; i++) begin
        s4_r[0].sgn[i] <= s3_r[SQ].c[i][C_W-1];
        d2_rem0_r[i]   <= DEN_W'(num_f[i][NUM2_W-1:QB]);
        d2_low0_r[i]   <= num_f[i][QB-1:0];
      end
    end
  end

  // ------------------------------------------- normalizing divide, 4 lanes
  logic [DEN_W-1:0] d2_rem [4][DV+1];
  logic [QB-1:0]    d2_low [4][DV+1];
  logic [QB-1:0]    d2_quo [4][DV+1];
  logic [DEN_W-1:0] d2_den [4][DV+1];

  for (genvar k = 0; k < 4; k++) begin : g_d2_lane
    assign d2_rem[k][0] = d2_rem0_r[k];
    assign d2_low[k][0] = d2_low0_r[k];
    assign d2_quo[k][0] = '0;
    assign d2_den[k][0] = d2_den0_r;
    for (genvar s = 0; s < DV; s++) begin : g_cell
      dcmq_div_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .rem_i (d2_rem[k][s]),
        .low_i (d2_low[k][s]),
        .quo_i (d2_quo[k][s]),
        .den_i (d2_den[k][s]),
        .rem_o (d2_rem[k][s+1]),
        .low_o (d2_low[k][s+1]),
        .quo_o (d2_quo[k][s+1]),
        .den_o (d2_den[k][s+1])
      );
    end
  end

  // ------------------------------------------------- stage G and output reg
  logic [QB-1:0]        qm_g [4];
  logic signed [DW-1:0] q_g  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qm_g[i] = (d2_quo[i][DV] > QB'(ONE)) ? QB'(ONE) : d2_quo[i][DV];
      q_g[i]  = s4_r[DV].bad ? '0 :
                s4_r[DV].sgn[i] ? -DW'(qm_g[i]) : DW'(qm_g[i]);
    end
  end

  logic                 out_valid_r;
  logic signed [DW-1:0] q0_r, q1_r, q2_r, q3_r;
  logic                 status_r;

  assign out_ld   = !out_valid_r || out_ready;
  assign adv      = !v4_r[DV] || out_ld;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= v4_r[DV];
      q0_r        <= q_g[0];
      q1_r        <= q_g[1];
      q2_r        <= q_g[2];
      q3_r        <= q_g[3];
      status_r    <= s4_r[DV].bad;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_q_scalar = q0_r;
  assign out_q_i      = q1_r;
  assign out_q_j      = q2_r;
  assign out_q_k      = q3_r;
  assign out_status   = status_r;

  // --------------------------------------------------------------- checks
  `DCMQ_ASSERT_IMP(a_degen_zero, out_valid && out_status, (out_q_scalar == '0) && (out_q_i == '0) && (out_q_j == '0) && (out_q_k == '0))
  `DCMQ_ASSERT_IMP(a_full_stall, out_valid && !out_ready && v4_r[DV], !in_ready)
  `DCMQ_ASSERT_IMP(a_unit_range, out_valid && !out_status, (out_q_scalar <= DW'(ONE)) && (out_q_scalar >= -DW'(ONE)))
  `DCMQ_ASSERT_NXT(a_accept_enters, in_valid && in_ready, v1_r[0])

endmodule

// File: hdl/dcmq_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit of a restoring integer square root.
module dcmq_sqrt_cell import dcmq_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [RAD_W-1:0]  rad_o
);

  logic [REM_W+1:0]  sh;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RAD_W-1:0]  rad_r;

  assign sh    = {rem_i, rad_i[RAD_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_i, 2'b01});
  assign ge    = (sh >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? REM_W'(sh - trial) : REM_W'(sh);
      root_r <= {root_i[ROOT_W-2:0], ge};
      rad_r  <= rad_i << 2;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule

// File: hdl/dcmq_div_cell.sv
`timescale 1ns / 1ps
// One quotient bit of a restoring unsigned divide.
module dcmq_div_cell import dcmq_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [QB-1:0]    low_i,
  input  logic [QB-1:0]    quo_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [QB-1:0]    low_o,
  output logic [QB-1:0]    quo_o,
  output logic [DEN_W-1:0] den_o
);

  logic [DEN_W:0]   sh;
  logic             ge;
  logic [DEN_W-1:0] rem_r;
  logic [QB-1:0]    low_r;
  logic [QB-1:0]    quo_r;
  logic [DEN_W-1:0] den_r;

  assign sh = {rem_i, low_i[QB-1]};
  assign ge = (sh >= {1'b0, den_i});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? DEN_W'(sh - {1'b0, den_i}) : DEN_W'(sh);
      low_r <= low_i << 1;
      quo_r <= {quo_i[QB-2:0], ge};
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign low_o = low_r;
  assign quo_o = quo_r;
  assign den_o = den_r;

endmodule

// File: tb/dcm_to_quaternion_unit_test.sv
`timescale 1ns / 1ps
module dcm_to_quaternion_unit_test;
  import dcmq_pkg::*;

  typedef logic signed [DW-1:0] elem_t;

  // One matrix transaction, row-major m00..m22.
  typedef struct {
    elem_t m [9];
  } dcm_t;

  // One quaternion transaction: q0 scalar, q1..q3 vector, degenerate flag.
  typedef struct {
    elem_t q [4];
    logic  status;
  } quat_t;

  // Holds predicted quaternions in order; computes them in fixed point.
  class quat_scoreboard;
    quat_t pending [$];

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    static function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // (num * 2^F) / den truncated toward zero
    static function longint frac_div(longint num, longint unsigned den);
      longint unsigned mg;
      longint unsigned qt;
      mg = (num < 0) ? longint'(-num) : longint'(num);
      qt = (mg << FRAC_BITS) / den;
      return (num < 0) ? -longint'(qt) : longint'(qt);
    endfunction

    function void note_input(dcm_t d);
      longint a [9];
      longint c [4];
      longint n [3];
      longint tr, dg, arg, one, pre;
      longint unsigned p, ss, mg, mag;
      piv_t piv;
      bit bad;
      int k;
      quat_t r;
      one = longint'(ONE);
      pre = longint'(PRE_LIM);
      for (int i = 0; i < 9; i++) a[i] = longint'(d.m[i]);
      for (int i = 0; i < 4; i++) c[i] = 0;
      bad = 0;
      tr = a[0] + a[4] + a[8];
      if (tr > a[0] && tr > a[4] && tr > a[8]) begin
        piv = PIV_T; dg = tr;
        n[0] = a[5] - a[7]; n[1] = a[6] - a[2]; n[2] = a[1] - a[3];
        if (!(tr > 0)) bad = 1;
      end else if (a[0] > a[4] && a[0] > a[8]) begin
        piv = PIV_I; dg = a[0];
        n[0] = a[5] - a[7]; n[1] = a[1] + a[3]; n[2] = a[6] + a[2];
      end else if (a[4] > a[8]) begin
        piv = PIV_J; dg = a[4];
        n[0] = a[6] - a[2]; n[1] = a[1] + a[3]; n[2] = a[5] + a[7];
      end else begin
        piv = PIV_K; dg = a[8];
        n[0] = a[1] - a[3]; n[1] = a[6] + a[2]; n[2] = a[5] + a[7];
      end
      if (!bad) begin
        arg = one + 2 * dg - tr;
        if (arg < 0) begin
          bad = 1;
        end else begin
          p = int_sqrt(longint'(arg) << (FRAC_BITS - 2));
          if (p == 0) begin
            bad = 1;
          end else begin
            k = 0;
            for (int i = 0; i < 4; i++) begin
              if (i == int'(piv)) begin
                c[i] = clip(longint'(p), pre);
              end else begin
                c[i] = clip(frac_div(n[k], 4 * p), pre);
                k++;
              end
            end
          end
        end
      end
      if (!bad) begin
        ss = 0;
        for (int i = 0; i < 4; i++) begin
          mg = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
          ss = ss + mg * mg;
        end
        mag = int_sqrt(ss);
        if (mag == 0) bad = 1;
        else for (int i = 0; i < 4; i++) c[i] = clip(frac_div(c[i], mag), one);
      end
      for (int i = 0; i < 4; i++) r.q[i] = bad ? '0 : elem_t'(c[i]);
      r.status = bad;
      pending.push_back(r);
    endfunction

    // Returns an empty string on a match, else a description.
    function string check_result(quat_t got);
      quat_t exp_q;
      string s;
      if (pending.size() == 0) return "quaternion with no matrix outstanding";
      exp_q = pending.pop_front();
      s = "";
      for (int i = 0; i < 4; i++)
        if (got.q[i] !== exp_q.q[i])
          s = {s, $sformatf(" q%0d got %0d exp %0d", i, got.q[i], exp_q.q[i])};
      if (got.status !== exp_q.status)
        s = {s, $sformatf(" status got %0b exp %0b", got.status, exp_q.status)};
      return s;
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  elem_t in_m [9];
  logic  out_valid;
  logic  out_ready = 1'b0;
  elem_t out_q_scalar, out_q_i, out_q_j, out_q_k;
  logic  out_status;

  quat_scoreboard sb;
  int    errors = 0;
  int    accepted = 0;
  bit    stim_done = 0;
  bit    hold_done = 0;

  localparam int LATENCY     = 81;
  localparam int IDLE_LIMIT  = 3000;  // covers the long receiver hold-off plus the pipe
  localparam int NUM_RANDOM  = 1750;
  localparam int HOLD_CYCLES = 300;   // well past the pipe depth, so in_ready drops

  initial for (int i = 0; i < 9; i++) in_m[i] = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dcm_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_q_scalar(out_q_scalar), .out_q_i(out_q_i),
    .out_q_j(out_q_j), .out_q_k(out_q_k), .out_status(out_status)
  );

  task automatic report(string msg);
    $display("mismatch @%0t:%s", $realtime, msg);
    errors++;
  endtask

  // Gap length: mostly none, sometimes short, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  function automatic real urand_sym();
    return 2.0 * (real'($urandom) / 4294967295.0) - 1.0;
  endfunction

  function automatic elem_t to_fix(real x, int jitter);
    int v;
    v = $rtoi(x * 65536.0) + jitter;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return elem_t'(v);
  endfunction

  // Proper rotation from a random quaternion, with an optional jitter per element.
  function automatic dcm_t rand_rotation(int jit);
    real a, b, c, d, nrm;
    real e [9];
    dcm_t t;
    do begin
      a = urand_sym(); b = urand_sym(); c = urand_sym(); d = urand_sym();
      nrm = a * a + b * b + c * c + d * d;
    end while (nrm < 0.01);
    nrm = $sqrt(nrm);
    a = a / nrm; b = b / nrm; c = c / nrm; d = d / nrm;
    e[0] = a * a + b * b - c * c - d * d;
    e[1] = 2.0 * (b * c + a * d);
    e[2] = 2.0 * (b * d - a * c);
    e[3] = 2.0 * (b * c - a * d);
    e[4] = a * a - b * b + c * c - d * d;
    e[5] = 2.0 * (c * d + a * b);
    e[6] = 2.0 * (b * d + a * c);
    e[7] = 2.0 * (c * d - a * b);
    e[8] = a * a - b * b - c * c + d * d;
    for (int i = 0; i < 9; i++)
      t.m[i] = to_fix(e[i], (jit == 0) ? 0 : int'($urandom_range(2 * jit)) - jit);
    return t;
  endfunction

  function automatic dcm_t diag_mat(int d0, int d1, int d2, int off);
    dcm_t t;
    for (int i = 0; i < 9; i++) t.m[i] = elem_t'(off);
    t.m[0] = elem_t'(d0); t.m[4] = elem_t'(d1); t.m[8] = elem_t'(d2);
    return t;
  endfunction

  // Present one matrix and hold it until the block takes it.
  task automatic send_matrix(dcm_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_m = t.m;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
    accepted++;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    dcm_t t;
    int r;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: every branch, ties and extreme values.
    send_matrix(diag_mat(65536, 65536, 65536, 0));      // identity, trace branch
    send_matrix(diag_mat(65536, -65536, -65536, 0));    // i branch
    send_matrix(diag_mat(-65536, 65536, -65536, 0));    // j branch
    send_matrix(diag_mat(-65536, -65536, 65536, 0));    // k branch
    send_matrix(diag_mat(0, 0, 0, 0));                  // all ties, falls to k
    send_matrix(diag_mat(100, 100, 50, 7));             // tie between m00 and m11
    send_matrix(diag_mat(65536, 65536, 65536, 65536));  // all max
    send_matrix(diag_mat(-65536, -65536, -65536, -65536));
    send_matrix(diag_mat(131071, 131070, 131070, 0));   // trace branch, diagonal near the field limit
    send_matrix(diag_mat(100000, 82768, 82768, 5));     // trace branch, m00 largest diagonal
    send_matrix(diag_mat(100000, 82768, 82767, 131071)); // trace branch, equal off-diagonals
    send_matrix(diag_mat(100000, 82768, 82767, -131072));
    send_matrix(diag_mat(-131072, -131072, -131072, 131071)); // most negative diagonal, most positive off-diagonals
    send_matrix(diag_mat(131071, 131071, 131071, -1));
    for (int i = 0; i < 6; i++) send_matrix(rand_rotation(0));

    // Random: mostly rotations, some heavily perturbed, some raw noise.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        t = rand_rotation($urandom_range(4));
      end else if (r < 85) begin
        t = rand_rotation($urandom_range(4000, 100));
      end else if (r < 95) begin
        for (int i = 0; i < 9; i++)
          t.m[i] = elem_t'(int'($urandom_range(131072)) - 65536);
      end else begin
        for (int i = 0; i < 9; i++) t.m[i] = elem_t'($urandom);
      end
      send_matrix(t);
    end
    in_valid = 1'b0;
    stim_done = 1;
  end

  // Receiver backpressure; one long hold-off once the stream is under way.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && accepted >= 300) begin
        hold_done = 1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = 1'b1;
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    quat_t got;
    string msg;
    if (rst_n && out_valid && out_ready) begin
      got.q[0] = out_q_scalar;
      got.q[1] = out_q_i;
      got.q[2] = out_q_j;
      got.q[3] = out_q_k;
      got.status = out_status;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle);
        $display("status: fail");
        $finish;
      end
    end
  end

  // End of test: drain, then keep watching for stragglers before the verdict.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0d quaternions never arrived", sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/dcmq_pkg.sv
hdl/dcmq_sqrt_cell.sv
hdl/dcmq_div_cell.sv
hdl/dcm_to_quaternion_unit.sv
tb/dcm_to_quaternion_unit_test.sv
